>>> hw/rtl/rsgc_pkg.sv
// ----------------------------------------------------------------------------
// rsgc_pkg
// shared types, codes and constants of the race start gate controller
// ----------------------------------------------------------------------------
package rsgc_pkg;

    // width of captured and reported time stamps inside the block
    localparam int TIME_BITS = 32;

    // event codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_CROSS  = 2'd1;
    localparam logic [1:0] FUNC_BUTTON = 2'd2;

    // operating modes
    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_SETUP = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_RELOAD    = 3'd1;
    localparam logic [2:0] REG_ARMED     = 3'd2;
    localparam logic [2:0] REG_READY     = 3'd3;
    localparam logic [2:0] REG_VOID_SECS = 3'd4;

    // register reset values
    localparam logic [7:0] RST_RELOAD    = 8'd30;
    localparam logic [7:0] RST_ARMED     = 8'd5;
    localparam logic [7:0] RST_READY     = 8'd10;
    localparam logic [7:0] RST_VOID_SECS = 8'd5;

    // setup mode countdown presets
    localparam logic [7:0] SETUP_SHORT = 8'd3;
    localparam logic [7:0] SETUP_MID   = 8'd30;
    localparam logic [7:0] SETUP_LONG  = 8'd60;

    typedef enum logic [2:0] {
        PH_NONE   = 3'd0,
        PH_READY  = 3'd1,
        PH_CLOSED = 3'd2,
        PH_OPEN   = 3'd3,
        PH_FALSE  = 3'd4
    } t_phase;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic green;
        logic red;
        logic yellow;
    } t_lamps;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] reload;
        logic [7:0] armed;
        logic [7:0] ready;
        logic [7:0] void_secs;
    } t_cfg;

    typedef struct packed {
        logic [7:0] seconds_left;
        t_phase     phase;
        t_time      captured;
        t_lamps     lamps;
    } t_state;

endpackage

>>> hw/rtl/rsgc_cfg.sv
// ----------------------------------------------------------------------------
// rsgc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module rsgc_cfg
    import rsgc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:      n_cfg.mode      = i_cfg_data[1:0];
                REG_RELOAD:    n_cfg.reload    = i_cfg_data;
                REG_ARMED:     n_cfg.armed     = i_cfg_data;
                REG_READY:     n_cfg.ready     = i_cfg_data;
                REG_VOID_SECS: n_cfg.void_secs = i_cfg_data;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_AUTO;
            r_cfg.reload    <= RST_RELOAD;
            r_cfg.armed     <= RST_ARMED;
            r_cfg.ready     <= RST_READY;
            r_cfg.void_secs <= RST_VOID_SECS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/rsgc_step.sv
// ----------------------------------------------------------------------------
// rsgc_step
// next gate state and report for one event
// ----------------------------------------------------------------------------
module rsgc_step
    import rsgc_pkg::*;
(
    input  logic [1:0]  i_func,
    input  logic [31:0] i_now,
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    output t_state      o_state,
    output logic        o_report_valid,
    output logic [31:0] o_report_time
);

    t_state     s;
    logic       rep_v;
    t_time      rep_t;
    t_time      now_t;
    logic [7:0] void_at;

    assign now_t   = TIME_BITS'(i_now);
    assign void_at = i_cfg.reload - i_cfg.void_secs;

    always_comb begin
        s     = i_state;
        rep_v = 1'b0;
        rep_t = '0;
        case (i_func)
            FUNC_TICK: begin
                if (i_cfg.mode == MODE_AUTO) begin
                    s.seconds_left = i_state.seconds_left - 8'd1;
                    if (s.seconds_left == i_cfg.armed) begin
                        s.phase = PH_CLOSED;
                    end else if (s.seconds_left == i_cfg.ready) begin
                        s.phase = PH_READY;
                    end else if (s.seconds_left == 8'd0) begin
                        s.lamps.green = 1'b1;
                        s.captured    = now_t;
                        if (i_state.phase == PH_FALSE) begin
                            rep_v   = 1'b1;
                            rep_t   = now_t;
                            s.phase = PH_NONE;
                        end else begin
                            s.phase = PH_OPEN;
                        end
                        s.seconds_left = i_cfg.reload;
                    end
                    // start goes void void_secs seconds after the reload, if reload >= void_secs
                    if (i_cfg.reload >= i_cfg.void_secs && s.seconds_left == void_at) begin
                        s.phase       = PH_NONE;
                        s.lamps.green = 1'b0;
                        s.lamps.red   = 1'b0;
                    end
                end else if (i_cfg.mode == MODE_EXT) begin
                    if (i_state.seconds_left != 8'd0) begin
                        s.seconds_left = i_state.seconds_left - 8'd1;
                    end
                    if (s.seconds_left == 8'd0 && i_state.phase == PH_OPEN) begin
                        s.lamps.green = 1'b1;
                    end
                end
            end
            FUNC_CROSS: begin
                s.lamps.yellow = ~i_state.lamps.yellow;
                if (i_cfg.mode == MODE_AUTO) begin
                    case (i_state.phase)
                        PH_CLOSED: begin
                            s.lamps.red = 1'b1;
                            s.phase     = PH_FALSE;
                        end
                        PH_OPEN: begin
                            s.lamps.green = 1'b0;
                            rep_v         = 1'b1;
                            rep_t         = i_state.captured;
                            s.phase       = PH_NONE;
                        end
                        PH_READY: begin
                            s.lamps.red    = 1'b1;
                            s.seconds_left = i_cfg.reload;
                            s.phase        = PH_NONE;
                        end
                        default: s.phase = i_state.phase;
                    endcase
                end else if (i_cfg.mode == MODE_EXT) begin
                    if (i_state.phase == PH_OPEN) begin
                        rep_v         = 1'b1;
                        rep_t         = now_t;
                        s.lamps.green = 1'b0;
                        s.phase       = PH_NONE;
                    end
                end
            end
            FUNC_BUTTON: begin
                if (i_cfg.mode == MODE_EXT) begin
                    s.lamps.green  = 1'b0;
                    s.seconds_left = i_cfg.reload;
                    s.phase        = PH_OPEN;
                end else if (i_cfg.mode == MODE_SETUP) begin
                    if (i_state.seconds_left == SETUP_MID) begin
                        s.seconds_left = SETUP_LONG;
                    end else if (i_state.seconds_left == SETUP_LONG) begin
                        s.seconds_left = SETUP_SHORT;
                    end else if (i_state.seconds_left == SETUP_SHORT) begin
                        s.seconds_left = SETUP_MID;
                    end
                end
            end
            default: s = i_state;
        endcase
    end

    assign o_state        = s;
    assign o_report_valid = rep_v;
    assign o_report_time  = 32'(rep_t);

endmodule

>>> hw/rtl/race_start_gate_controller_top.sv
// ----------------------------------------------------------------------------
// race_start_gate_controller_top
// start gate controller: countdown, gate phase, lamps and start time report
// ----------------------------------------------------------------------------
// Each request is one event (second tick, photocell crossing or button press)
// with its time stamp, and yields exactly one result: countdown, gate state,
// the three lamps and an optional reported start time. The block takes one
// request per clock cycle unless results stall. A request is registered in
// the input register, the gate state update is a single pass of compares and
// a decrement, and the result is registered in the output register, where it
// is valid and can be taken. The request in the input register moves on when
// the output register is empty or its result is taken in that cycle; a new
// request is taken whenever the input register is empty or moving on, so with
// no result stalls one request goes in every cycle. The user must write
// configuration registers only while no request is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module race_start_gate_controller_top
    import rsgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,

    // event requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_now_time,

    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_countdown,
    output logic [2:0]  o_gate_state,
    output logic        o_green_lamp,
    output logic        o_red_lamp,
    output logic        o_yellow_lamp,
    output logic        o_report_valid,
    output logic [31:0] o_report_time
);

    t_cfg        cfg;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [31:0] r_now;

    // gate state
    t_state      r_state;
    t_state      n_state;
    logic        n_rep_valid;
    logic [31:0] n_rep_time;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_countdown;
    logic [2:0]  r_gate_state;
    t_lamps      r_lamps;
    logic        r_rep_valid;
    logic [31:0] r_rep_time;

    logic        advance;
    logic        in_take;

    // the input stage moves on when the output register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    rsgc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rsgc_step u_step (
        .i_func         (r_func),
        .i_now          (r_now),
        .i_cfg          (cfg),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_report_valid (n_rep_valid),
        .o_report_time  (n_rep_time)
    );

    // input register, payload unreset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= i_func;
            r_now  <= i_now_time;
        end
    end

    // gate state commits as the event moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.seconds_left <= RST_RELOAD;
            r_state.phase        <= PH_NONE;
            r_state.captured     <= '0;
            r_state.lamps        <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_countdown  <= n_state.seconds_left;
            r_gate_state <= n_state.phase;
            r_lamps      <= n_state.lamps;
            r_rep_valid  <= n_rep_valid;
            r_rep_time   <= n_rep_time;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_countdown    = r_countdown;
    assign o_gate_state   = r_gate_state;
    assign o_green_lamp   = r_lamps.green;
    assign o_red_lamp     = r_lamps.red;
    assign o_yellow_lamp  = r_lamps.yellow;
    assign o_report_valid = r_rep_valid;
    assign o_report_time  = r_rep_time;

`ifndef SYNTH
    // every report closes the run, so the gate is back at no start
    a_report_clears_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_valid) |-> (o_gate_state == PH_NONE))
        else $error("report with gate not at no start");

    // report time is zero unless a time is reported
    a_report_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_report_time == 32'd0))
        else $error("report time nonzero without report");

    // an event that leaves the input register shows up as a result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced event produced no result");
`endif

endmodule

>>> tb/sv/tb_race_start_gate_controller_top.sv
// ----------------------------------------------------------------------------
// tb_race_start_gate_controller_top
// self-checking bench for the race start gate controller
// ----------------------------------------------------------------------------
// Event requests (tick, crossing, button, and the unused code) go in under
// random source gaps. Results come out under random sink stalls. A per-request
// tracker of countdown, gate phase, captured start and lamps predicts one
// result per accepted request, and every result is checked field by field.
// The run starts with a short directed walk through the modes and corner
// cases. After that come phases with different register settings, extremes
// among them, each filled with random events biased toward full countdown
// sequences.
// ----------------------------------------------------------------------------
module tb_race_start_gate_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsgc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_IDLE   = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          PHASES      = 16;

    // one result as seen on the output side
    typedef struct packed {
        logic [7:0]  countdown;
        t_phase      phase;
        t_lamps      lamps;
        logic        report_valid;
        logic [31:0] report_time;
    } t_gate_result;

    // ------------------------------------------------------------------------
    // gate tracker: predicts each result and keeps the ones still due
    // ------------------------------------------------------------------------
    class start_gate_tracker;
        t_cfg         cfg;
        logic [7:0]   seconds_left;
        t_phase       phase;
        t_time        captured;
        t_lamps       lamps;
        t_gate_result results_due[$];
        int unsigned  errors;

        function new();
            cfg          = '{mode: MODE_AUTO, reload: RST_RELOAD, armed: RST_ARMED,
                             ready: RST_READY, void_secs: RST_VOID_SECS};
            seconds_left = RST_RELOAD;
            phase        = PH_NONE;
            captured     = '0;
            lamps        = '0;
            errors       = 0;
        endfunction

        // register indexes past the last one are dropped
        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                REG_MODE:      cfg.mode      = data[1:0];
                REG_RELOAD:    cfg.reload    = data;
                REG_ARMED:     cfg.armed     = data;
                REG_READY:     cfg.ready     = data;
                REG_VOID_SECS: cfg.void_secs = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // accepted request: advance the gate and queue the result it yields
        function void note_request(logic [1:0] func, logic [31:0] now);
            t_gate_result r;
            r.report_valid = 1'b0;
            r.report_time  = '0;
            case (func)
                FUNC_TICK: begin
                    if (cfg.mode == MODE_AUTO) begin
                        seconds_left = seconds_left - 8'd1;
                        // armed wins over ready, ready over zero
                        if (seconds_left == cfg.armed) begin
                            phase = PH_CLOSED;
                        end else if (seconds_left == cfg.ready) begin
                            phase = PH_READY;
                        end else if (seconds_left == 8'd0) begin
                            lamps.green = 1'b1;
                            captured    = t_time'(now);
                            if (phase == PH_FALSE) begin
                                r.report_valid = 1'b1;
                                r.report_time  = 32'(captured);
                                phase          = PH_NONE;
                            end else begin
                                phase = PH_OPEN;
                            end
                            seconds_left = cfg.reload;
                        end
                        // start void after the no-start window
                        if (cfg.reload >= cfg.void_secs &&
                            seconds_left == 8'(cfg.reload - cfg.void_secs)) begin
                            phase       = PH_NONE;
                            lamps.green = 1'b0;
                            lamps.red   = 1'b0;
                        end
                    end else if (cfg.mode == MODE_EXT) begin
                        if (seconds_left != 8'd0)
                            seconds_left = seconds_left - 8'd1;
                        if (seconds_left == 8'd0 && phase == PH_OPEN)
                            lamps.green = 1'b1;
                    end
                end
                FUNC_CROSS: begin
                    lamps.yellow = ~lamps.yellow;
                    if (cfg.mode == MODE_AUTO) begin
                        if (phase == PH_CLOSED) begin
                            lamps.red = 1'b1;
                            phase     = PH_FALSE;
                        end else if (phase == PH_OPEN) begin
                            lamps.green    = 1'b0;
                            r.report_valid = 1'b1;
                            r.report_time  = 32'(captured);
                            phase          = PH_NONE;
                        end else if (phase == PH_READY) begin
                            lamps.red    = 1'b1;
                            seconds_left = cfg.reload;
                            phase        = PH_NONE;
                        end
                    end else if (cfg.mode == MODE_EXT) begin
                        if (phase == PH_OPEN) begin
                            r.report_valid = 1'b1;
                            r.report_time  = now;
                            lamps.green    = 1'b0;
                            phase          = PH_NONE;
                        end
                    end
                end
                FUNC_BUTTON: begin
                    if (cfg.mode == MODE_EXT) begin
                        lamps.green  = 1'b0;
                        seconds_left = cfg.reload;
                        phase        = PH_OPEN;
                    end else if (cfg.mode == MODE_SETUP) begin
                        if (seconds_left == SETUP_MID)
                            seconds_left = SETUP_LONG;
                        else if (seconds_left == SETUP_LONG)
                            seconds_left = SETUP_SHORT;
                        else if (seconds_left == SETUP_SHORT)
                            seconds_left = SETUP_MID;
                    end
                end
                default: ;
            endcase
            r.countdown = seconds_left;
            r.phase     = phase;
            r.lamps     = lamps;
            results_due.push_back(r);
        endfunction

        function void check_field(string label, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, label, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_gate_result seen);
            t_gate_result want;
            if (results_due.size() == 0) begin
                $display("%0t ns: result with no request pending, expected none, actual %h",
                         $time, seen);
                errors++;
                return;
            end
            want = results_due.pop_front();
            check_field("countdown",    want.countdown,    seen.countdown);
            check_field("gate_state",   want.phase,        seen.phase);
            check_field("green_lamp",   want.lamps.green,  seen.lamps.green);
            check_field("red_lamp",     want.lamps.red,    seen.lamps.red);
            check_field("yellow_lamp",  want.lamps.yellow, seen.lamps.yellow);
            check_field("report_valid", want.report_valid, seen.report_valid);
            check_field("report_time",  want.report_time,  seen.report_time);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [31:0] i_now_time;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_countdown;
    logic [2:0]  o_gate_state;
    logic        o_green_lamp;
    logic        o_red_lamp;
    logic        o_yellow_lamp;
    logic        o_report_valid;
    logic [31:0] o_report_time;

    race_start_gate_controller_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_countdown    (o_countdown),
        .o_gate_state   (o_gate_state),
        .o_green_lamp   (o_green_lamp),
        .o_red_lamp     (o_red_lamp),
        .o_yellow_lamp  (o_yellow_lamp),
        .o_report_valid (o_report_valid),
        .o_report_time  (o_report_time)
    );

    start_gate_tracker gate = new();

    // idling switches, turned off for the closing phases
    logic        src_gaps    = 1'b1;
    logic        sink_stalls = 1'b1;
    int unsigned cycles      = 0;

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL race_start_gate_controller_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check results first, then note new requests, all at the edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_gate_result seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen.countdown    = o_countdown;
                seen.phase        = t_phase'(o_gate_state);
                seen.lamps.green  = o_green_lamp;
                seen.lamps.red    = o_red_lamp;
                seen.lamps.yellow = o_yellow_lamp;
                seen.report_valid = o_report_valid;
                seen.report_time  = o_report_time;
                gate.check_result(seen);
            end
            if (i_in_valid && !o_in_stall)
                gate.note_request(i_func, i_now_time);
        end
    end

    // result side: random stall bursts
    initial begin : result_sink
        int unsigned burst;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 19);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one event request, held until accepted
    task automatic send_request(input logic [1:0] func, input logic [31:0] now);
        int unsigned gap;
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_now_time <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gate.write_reg(idx, data);
    endtask

    // stop sending and wait for every result, then an idle tail
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (gate.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // event mix per mode, mostly the events that move that mode along
    function automatic logic [1:0] pick_event(logic [1:0] mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_AUTO:  return r < 80 ? FUNC_TICK : r < 94 ? FUNC_CROSS :
                               r < 97 ? FUNC_BUTTON : FUNC_IDLE;
            MODE_EXT:   return r < 55 ? FUNC_TICK : r < 78 ? FUNC_CROSS :
                               r < 95 ? FUNC_BUTTON : FUNC_IDLE;
            MODE_SETUP: return r < 20 ? FUNC_TICK : r < 35 ? FUNC_CROSS :
                               r < 95 ? FUNC_BUTTON : FUNC_IDLE;
            default:    return r < 40 ? FUNC_TICK : r < 70 ? FUNC_CROSS :
                               r < 95 ? FUNC_BUTTON : FUNC_IDLE;
        endcase
    endfunction

    // time stamps, with the all-zero and all-one extremes now and then
    function automatic logic [31:0] pick_stamp();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // one settings phase: registers, optional countdown load, random events
    task automatic run_phase(input int p, input int unsigned n_items);
        t_cfg        c;
        int unsigned k;
        case (p)
            // all thresholds at the top
            0: c = '{mode: MODE_AUTO, reload: 8'd255, armed: 8'd255, ready: 8'd255,
                     void_secs: 8'd255};
            // all at the bottom: gate closes at zero, countdown wraps
            1: c = '{mode: MODE_AUTO, reload: 8'd1, armed: 8'd0, ready: 8'd0,
                     void_secs: 8'd0};
            // armed and ready on the same value
            2: c = '{mode: MODE_AUTO, reload: 8'd8, armed: 8'd3, ready: 8'd3,
                     void_secs: 8'd2};
            3: c = '{mode: MODE_EXT, reload: 8'd5, armed: 8'd2, ready: 8'd4,
                     void_secs: 8'd1};
            4: c = '{mode: MODE_SETUP, reload: SETUP_MID, armed: 8'd0, ready: 8'd0,
                     void_secs: 8'd255};
            5: c = '{mode: MODE_UNUSED, reload: 8'd12, armed: 8'd4, ready: 8'd8,
                     void_secs: 8'd3};
            default: begin
                k = $urandom_range(0, 9);
                c.mode = k < 6 ? MODE_AUTO : k < 8 ? MODE_EXT :
                         k == 8 ? MODE_SETUP : MODE_UNUSED;
                if (c.mode == MODE_SETUP) begin
                    k = $urandom_range(0, 2);
                    c.reload = k == 0 ? SETUP_SHORT : k == 1 ? SETUP_MID : SETUP_LONG;
                end else if ($urandom_range(0, 4) == 0) begin
                    c.reload = 8'($urandom_range(1, 255));
                end else begin
                    c.reload = 8'($urandom_range(2, 20));
                end
                c.armed     = 8'($urandom_range(0, c.reload));
                c.ready     = 8'($urandom_range(0, c.reload));
                c.void_secs = 8'($urandom_range(0, c.reload + 3));
                if ($urandom_range(0, 7) == 0)
                    c.ready = 8'($urandom);
            end
        endcase

        // the closing phases run with no idling at all
        if (p >= PHASES - 2) begin
            src_gaps    = 1'b0;
            sink_stalls = 1'b0;
        end else begin
            src_gaps    = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
        end

        write_reg(REG_RELOAD, c.reload);
        write_reg(REG_ARMED, c.armed);
        write_reg(REG_READY, c.ready);
        write_reg(REG_VOID_SECS, c.void_secs);
        // indexes past the last register must be dropped
        write_reg(3'(REG_VOID_SECS + $urandom_range(1, 3)), 8'($urandom));

        // load the countdown from the reload value via an external start
        if ((c.mode == MODE_AUTO || c.mode == MODE_SETUP) &&
            (p < 3 || $urandom_range(0, 3) != 0)) begin
            write_reg(REG_MODE, {6'd0, MODE_EXT});
            send_request(FUNC_BUTTON, pick_stamp());
            drain();
        end
        // upper data bits are junk, only the low two count
        write_reg(REG_MODE, {6'($urandom), c.mode});

        repeat (n_items) send_request(pick_event(c.mode), pick_stamp());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func     = FUNC_TICK;
        i_now_time = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: crossing at no start, unused event, button in auto, a tick
        send_request(FUNC_CROSS, 32'h0000_0000);
        send_request(FUNC_IDLE, 32'hFFFF_FFFF);
        send_request(FUNC_BUTTON, 32'h1234_5678);
        send_request(FUNC_TICK, 32'hFFFF_FFFF);
        drain();

        // external start, crossing reports its own time
        write_reg(REG_MODE, {6'd0, MODE_EXT});
        send_request(FUNC_BUTTON, 32'h0000_0001);
        send_request(FUNC_CROSS, 32'hA5A5_5A5A);
        send_request(FUNC_TICK, 32'h5A5A_A5A5);
        drain();

        // setup with a countdown off the preset cycle, then spare indexes
        write_reg(REG_MODE, {6'b111111, MODE_SETUP});
        write_reg(3'(REG_VOID_SECS + 1), 8'hFF);
        write_reg(3'(REG_VOID_SECS + 2), 8'h00);
        write_reg(3'(REG_VOID_SECS + 3), 8'h81);
        send_request(FUNC_BUTTON, 32'h0000_FFFF);
        send_request(FUNC_TICK, 32'hFFFF_0000);
        drain();

        // back to a countdown of 30 and walk the presets
        write_reg(REG_MODE, {6'd0, MODE_EXT});
        send_request(FUNC_BUTTON, 32'h0F0F_0F0F);
        drain();
        write_reg(REG_MODE, {6'd0, MODE_SETUP});
        repeat (3) send_request(FUNC_BUTTON, 32'hF0F0_F0F0);
        drain();

        // unused mode: only the crossing lamp moves
        write_reg(REG_MODE, {6'd0, MODE_UNUSED});
        send_request(FUNC_TICK, 32'h3333_3333);
        send_request(FUNC_BUTTON, 32'hCCCC_CCCC);
        send_request(FUNC_CROSS, 32'h5555_5555);
        drain();

        // false start on closed gate, reported at the zero tick, then void
        write_reg(REG_RELOAD, 8'd3);
        write_reg(REG_MODE, {6'd0, MODE_EXT});
        send_request(FUNC_BUTTON, 32'h0000_0000);
        drain();
        write_reg(REG_ARMED, 8'd2);
        write_reg(REG_READY, 8'd2);
        write_reg(REG_VOID_SECS, 8'd0);
        write_reg(REG_MODE, {6'd0, MODE_AUTO});
        send_request(FUNC_TICK, 32'h1111_1111);
        send_request(FUNC_CROSS, 32'h2222_2222);
        send_request(FUNC_TICK, 32'h4444_4444);
        send_request(FUNC_TICK, 32'h8000_0001);
        drain();

        // random phases, the first long enough to count down from the top
        for (int p = 0; p < PHASES; p++)
            run_phase(p, p == 0 ? 400 : 90);

        if (gate.errors == 0 && gate.pending() == 0)
            $display("PASS race_start_gate_controller_top");
        else
            $display("FAIL race_start_gate_controller_top");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rsgc_pkg.sv
hw/rtl/rsgc_cfg.sv
hw/rtl/rsgc_step.sv
hw/rtl/race_start_gate_controller_top.sv
tb/sv/tb_race_start_gate_controller_top.sv
